[hw/rtl/q4kd_pkg.sv]
// q4kd_pkg: types, constants and arithmetic helpers for the Q4_K dequantiser.
// Shared by the front, queue, back and top modules; no dependencies.
`default_nettype none
package q4kd_pkg;

    localparam logic [7:0] BLOCK_LAST  = 8'd143;
    localparam logic [7:0] SCALE_START = 8'd4;
    localparam logic [7:0] QUANT_START = 8'd16;
    localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
    localparam logic [7:0] EXP_BIAS_ADJ = 8'd102; // 127 - 25

    // One quant byte with everything the back end needs.
    typedef struct packed {
        logic [15:0] d_half;
        logic [15:0] m_half;
        logic [9:0]  lo_scq;
        logic [5:0]  lo_mn;
        logic [9:0]  hi_scq;
        logic [5:0]  hi_mn;
        logic [7:0]  pos;
        logic        blk_end;
    } t_item;

    // Exact products: value = (-1)^s * mag * 2^(e-25).
    typedef struct packed {
        logic        sa;
        logic [20:0] a;
        logic [4:0]  ea;
        logic        sb;
        logic [16:0] b;
        logic [4:0]  eb;
        logic        zs;
        logic        spec;
        logic [31:0] sbits;
    } t_prod;

    typedef struct packed {
        logic        neg;
        logic [50:0] mag;
        logic [4:0]  emin;
        logic [5:0]  lead;
        logic        zs;
        logic        spec;
        logic [31:0] sbits;
    } t_diff;

    typedef struct packed {
        logic [7:0] pos;
        logic       blk_end;
    } t_tag;

    // 6-bit scale and min of sub-block sub from the twelve packed bytes.
    function automatic logic [11:0] f_scmin(input logic [95:0] pk, input logic [2:0] sub);
        logic [7:0]  p [12];
        logic [11:0] r [8];
        for (int k = 0; k < 12; k++) begin
            p[k] = pk[8*k +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            r[i]     = {p[i][5:0], p[i+4][5:0]};
            r[i + 4] = {p[i][7:6], p[i+8][3:0], p[i+4][7:6], p[i+8][7:4]};
        end
        return r[sub];
    endfunction

    // Half decode, products and special-value resolution for one lane.
    function automatic t_prod f_stage1(input logic [15:0] dh, input logic [15:0] mh,
                                       input logic [9:0] scq, input logic [5:0] mn);
        t_prod       o;
        logic [10:0] md;
        logic [10:0] mm;
        logic        dnan;
        logic        dinf;
        logic        mnan;
        logic        minf;
        logic        a_nan;
        logic        a_inf;
        logic        b_nan;
        logic        b_inf;
        logic [31:0] a_bits;
        logic [31:0] b_bits;
        md   = {dh[14:10] != 5'd0, dh[9:0]};
        mm   = {mh[14:10] != 5'd0, mh[9:0]};
        dnan = (dh[14:10] == 5'h1f) && (dh[9:0] != 10'd0);
        dinf = (dh[14:10] == 5'h1f) && (dh[9:0] == 10'd0);
        mnan = (mh[14:10] == 5'h1f) && (mh[9:0] != 10'd0);
        minf = (mh[14:10] == 5'h1f) && (mh[9:0] == 10'd0);
        o.sa = dh[15];
        o.sb = mh[15];
        o.ea = (dh[14:10] == 5'd0) ? 5'd1 : dh[14:10];
        o.eb = (mh[14:10] == 5'd0) ? 5'd1 : mh[14:10];
        o.a  = 21'({10'd0, md} * {11'd0, scq});
        o.b  = 17'({6'd0, mm} * {11'd0, mn});
        o.zs = (o.a == 21'd0) && (o.b == 17'd0) && o.sa && !o.sb;
        // inf times zero gives the default NaN; NaN inputs come out quietened
        a_nan  = dnan || (dinf && scq == 10'd0);
        a_inf  = dinf && scq != 10'd0;
        b_nan  = mnan || (minf && mn == 6'd0);
        b_inf  = minf && mn != 6'd0;
        a_bits = dnan ? {dh[15], 8'hff, 1'b1, dh[8:0], 13'd0} : DEFAULT_NAN;
        b_bits = mnan ? {mh[15], 8'hff, 1'b1, mh[8:0], 13'd0} : DEFAULT_NAN;
        o.spec = a_nan || a_inf || b_nan || b_inf;
        if (a_nan) begin
            o.sbits = a_bits;
        end else if (b_nan) begin
            o.sbits = b_bits;
        end else if (a_inf && b_inf) begin
            o.sbits = (o.sa == o.sb) ? DEFAULT_NAN : {o.sa, 8'hff, 23'd0};
        end else if (a_inf) begin
            o.sbits = {o.sa, 8'hff, 23'd0};
        end else begin
            o.sbits = {!o.sb, 8'hff, 23'd0};
        end
        return o;
    endfunction

    // Exact a - b on a common exponent.
    function automatic t_diff f_stage2(input t_prod x);
        t_diff       o;
        logic [50:0] xa;
        logic [50:0] yb;
        logic [51:0] v;
        if (x.ea >= x.eb) begin
            xa     = {30'd0, x.a} << (x.ea - x.eb);
            yb     = {34'd0, x.b};
            o.emin = x.eb;
        end else begin
            xa     = {30'd0, x.a};
            yb     = {34'd0, x.b} << (x.eb - x.ea);
            o.emin = x.ea;
        end
        v = (x.sa ? -{1'b0, xa} : {1'b0, xa}) - (x.sb ? -{1'b0, yb} : {1'b0, yb});
        o.neg   = v[51];
        o.mag   = v[51] ? 51'(-v) : v[50:0];
        o.lead  = 6'd0;
        o.zs    = x.zs;
        o.spec  = x.spec;
        o.sbits = x.sbits;
        return o;
    endfunction

    function automatic logic [5:0] f_lead(input logic [50:0] mag);
        logic [5:0] l;
        l = 6'd0;
        for (int i = 0; i < 51; i++) begin
            if (mag[i]) begin
                l = 6'(i);
            end
        end
        return l;
    endfunction

    // Normalise, round to nearest even and pack. Never subnormal, never overflows.
    function automatic logic [31:0] f_round(input t_diff x);
        logic [50:0] norm;
        logic [22:0] mant;
        logic        rnd;
        logic [23:0] sum;
        logic [7:0]  ex;
        norm = x.mag << (6'd50 - x.lead);
        mant = norm[49:27];
        rnd  = norm[26] && ((|norm[25:0]) || mant[0]);
        sum  = {1'b0, mant} + {23'd0, rnd};
        ex   = 8'(x.lead) + 8'(x.emin) + EXP_BIAS_ADJ + 8'(sum[23]);
        if (x.spec) begin
            return x.sbits;
        end else if (x.mag == 51'd0) begin
            return {x.zs, 31'd0};
        end
        return {x.neg, ex, sum[22:0]};
    endfunction

endpackage
`default_nettype wire

[hw/rtl/q4k_block_dequantizer_unit.sv]
// q4k_block_dequantizer_unit: top level of the Q4_K block dequantiser.
// Instantiates q4kd_front, q4kd_queue and q4kd_back; uses q4kd_pkg.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------
//  input    | push / full       | i_block_byte
//  result   | empty / pop       | o_low_value, o_high_value, o_low_position,
//           |                   | o_block_end
//
// One byte per cycle is taken while the queue has room. The 16 header bytes
// give no result; each of the 128 quant bytes gives one transfer.
// A quant byte's result goes through the queue, which the front writes at the
// accepting edge, then through the four back stages (products, subtract,
// leading one, round); the result can be popped from the round stage register.
// Reset is synchronous, active low; header storage is not reset.
// A stalled pop backs up the back pipeline, then the queue, then raises full.
`default_nettype none
module q4k_block_dequantizer_unit
    import q4kd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_block_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [31:0]     o_low_value,
    output logic [31:0]     o_high_value,
    output logic [7:0]      o_low_position,
    output logic            o_block_end
);

    logic  fr_wr;
    t_item fr_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  bk_take;
    logic  acc;

    // Accept only when the queue has room, so the front never drops a quant byte.
    assign full = q_full;
    assign acc  = push && !q_full;

    q4kd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_byte  (i_block_byte),
        .o_wr    (fr_wr),
        .o_item  (fr_item)
    );

    q4kd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_wr),
        .i_item  (fr_item),
        .i_rd    (bk_take),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    q4kd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_take         (bk_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_low_value    (o_low_value),
        .o_high_value   (o_high_value),
        .o_low_position (o_low_position),
        .o_block_end    (o_block_end)
    );

endmodule
`default_nettype wire

[hw/rtl/q4kd_front.sv]
// q4kd_front: byte position tracking, header capture, quant byte classification.
// Uses q4kd_pkg.
`default_nettype none
module q4kd_front
    import q4kd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_byte,
    output logic            o_wr,
    output t_item           o_item
);

    logic [7:0]  r_pos;
    logic [7:0]  n_pos;
    logic [15:0] r_d_half;
    logic [15:0] r_m_half;
    logic [95:0] r_pk;
    logic [7:0]  j;
    logic [3:0]  pk_idx;
    logic [11:0] lo_sm;
    logic [11:0] hi_sm;

    assign n_pos  = (r_pos == BLOCK_LAST) ? 8'd0 : r_pos + 8'd1;
    assign j      = r_pos - QUANT_START;
    assign pk_idx = 4'(r_pos - SCALE_START);
    assign lo_sm  = f_scmin(r_pk, {j[6:5], 1'b0});
    assign hi_sm  = f_scmin(r_pk, {j[6:5], 1'b1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 8'd0;
        end else if (i_push) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            case (r_pos)
                8'd0: r_d_half[7:0]  <= i_byte;
                8'd1: r_d_half[15:8] <= i_byte;
                8'd2: r_m_half[7:0]  <= i_byte;
                8'd3: r_m_half[15:8] <= i_byte;
                default: begin
                    if (r_pos < QUANT_START) begin
                        r_pk[8*pk_idx +: 8] <= i_byte;
                    end
                end
            endcase
        end
    end

    assign o_wr            = i_push && (r_pos >= QUANT_START);
    assign o_item.d_half   = r_d_half;
    assign o_item.m_half   = r_m_half;
    assign o_item.lo_scq   = 10'({4'd0, lo_sm[11:6]} * {6'd0, i_byte[3:0]});
    assign o_item.lo_mn    = lo_sm[5:0];
    assign o_item.hi_scq   = 10'({4'd0, hi_sm[11:6]} * {6'd0, i_byte[7:4]});
    assign o_item.hi_mn    = hi_sm[5:0];
    assign o_item.pos      = {j[6:5], 1'b0, j[4:0]};
    assign o_item.blk_end  = (r_pos == BLOCK_LAST);

endmodule
`default_nettype wire

[hw/rtl/q4kd_queue.sv]
// q4kd_queue: short FIFO of classified items between front and back.
// Uses q4kd_pkg.
`default_nettype none
module q4kd_queue
    import q4kd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_item     i_item,
    input  wire logic i_rd,
    output logic      o_full,
    output logic      o_valid,
    output t_item     o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_ok;
    logic          rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            end
            if (rd_ok) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(wr_ok) - CW'(rd_ok);
        end
    end

endmodule
`default_nettype wire

[hw/rtl/q4kd_back.sv]
// q4kd_back: four-stage float pipeline (products, subtract, leading one, round).
// Uses q4kd_pkg; last stage is the output register.
`default_nettype none
module q4kd_back
    import q4kd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  t_item       i_item,
    output logic        o_take,
    input  wire logic   i_pop,
    output logic        o_empty,
    output logic [31:0] o_low_value,
    output logic [31:0] o_high_value,
    output logic [7:0]  o_low_position,
    output logic        o_block_end
);

    logic        r_v1, r_v2, r_v3, r_v4;
    t_prod       r_lo1, r_hi1;
    t_diff       r_lo2, r_hi2, r_lo3, r_hi3;
    t_tag        r_t1, r_t2, r_t3, r_t4;
    logic [31:0] r_lo4, r_hi4;
    logic        rdy1, rdy2, rdy3, rdy4;
    t_diff       lo_ld, hi_ld;

    assign rdy4   = !r_v4 || i_pop;
    assign rdy3   = !r_v3 || rdy4;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign o_take = i_valid && rdy1;

    // leading-one position folded into the stage-two result
    always_comb begin
        lo_ld      = r_lo2;
        lo_ld.lead = f_lead(r_lo2.mag);
        hi_ld      = r_hi2;
        hi_ld.lead = f_lead(r_hi2.mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_lo1 <= f_stage1(i_item.d_half, i_item.m_half, i_item.lo_scq, i_item.lo_mn);
            r_hi1 <= f_stage1(i_item.d_half, i_item.m_half, i_item.hi_scq, i_item.hi_mn);
            r_t1  <= '{pos: i_item.pos, blk_end: i_item.blk_end};
        end
        if (rdy2) begin
            r_lo2 <= f_stage2(r_lo1);
            r_hi2 <= f_stage2(r_hi1);
            r_t2  <= r_t1;
        end
        if (rdy3) begin
            r_lo3 <= lo_ld;
            r_hi3 <= hi_ld;
            r_t3  <= r_t2;
        end
        if (rdy4) begin
            r_lo4 <= f_round(r_lo3);
            r_hi4 <= f_round(r_hi3);
            r_t4  <= r_t3;
        end
    end

    assign o_empty        = !r_v4;
    assign o_low_value    = r_lo4;
    assign o_high_value   = r_hi4;
    assign o_low_position = r_t4.pos;
    assign o_block_end    = r_t4.blk_end;

endmodule
`default_nettype wire

[tb/q4kd_result_checker.sv]
// q4kd_result_checker: watches both queue channels of the Q4_K dequantiser,
// predicts each result from the byte stream and compares. No package needed.
`default_nettype none
module q4kd_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic [7:0]  i_block_byte,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic [31:0] i_low_value,
    input  wire logic [31:0] i_high_value,
    input  wire logic [7:0]  i_low_position,
    input  wire logic        i_block_end,
    output int               o_error_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  LAST_OFFSET  = 8'd143;
    localparam logic [7:0]  FIRST_QUANT  = 8'd16;
    localparam logic [31:0] QUIET_NAN    = 32'hffc0_0000;

    typedef struct packed {
        logic [31:0] low_value;
        logic [31:0] high_value;
        logic [7:0]  low_position;
        logic        block_end;
    } t_pair;

    t_pair      pair_queue[$];
    logic [7:0] offset;
    logic [15:0] scale_half;
    logic [15:0] min_half;
    logic [7:0] scale_bytes [12];
    int         errors;

    assign o_error_count = errors;
    assign o_pending     = pair_queue.size();

    // 6-bit scale (upper half) and min (lower half) of one sub-block
    function automatic logic [11:0] sub_scale_min(input logic [2:0] idx);
        if (idx < 3'd4) begin
            return {scale_bytes[idx][5:0], scale_bytes[idx + 4][5:0]};
        end
        return {scale_bytes[idx - 4][7:6], scale_bytes[idx + 4][3:0],
                scale_bytes[idx][7:6], scale_bytes[idx + 4][7:4]};
    endfunction

    // (d*sc*q) - (dmin*mn) in binary32, exact difference then one rounding
    function automatic logic [31:0] dequant_value(input logic [15:0] dh, input logic [15:0] mh,
                                                  input logic [5:0] sc, input logic [5:0] mn,
                                                  input logic [3:0] q);
        logic        dnan, dinf, mnan, minf, a_nan, a_inf, b_nan, b_inf;
        logic [9:0]  scq;
        int          de, me, emin, lead, shift, expo;
        longint      amag, bmag, diff, mag, kept, rest, halfway;
        logic        neg;
        scq  = 10'(sc) * 10'(q);
        dnan = dh[14:10] == 5'h1f && dh[9:0] != 10'd0;
        dinf = dh[14:10] == 5'h1f && dh[9:0] == 10'd0;
        mnan = mh[14:10] == 5'h1f && mh[9:0] != 10'd0;
        minf = mh[14:10] == 5'h1f && mh[9:0] == 10'd0;
        // inf times zero is the default NaN, incoming NaNs are quietened
        a_nan = dnan || (dinf && scq == 10'd0);
        a_inf = dinf && scq != 10'd0;
        b_nan = mnan || (minf && mn == 6'd0);
        b_inf = minf && mn != 6'd0;
        if (a_nan) begin
            return dnan ? {dh[15], 8'hff, 1'b1, dh[8:0], 13'd0} : QUIET_NAN;
        end
        if (b_nan) begin
            return mnan ? {mh[15], 8'hff, 1'b1, mh[8:0], 13'd0} : QUIET_NAN;
        end
        if (a_inf && b_inf) begin
            return (dh[15] == mh[15]) ? QUIET_NAN : {dh[15], 8'hff, 23'd0};
        end
        if (a_inf) begin
            return {dh[15], 8'hff, 23'd0};
        end
        if (b_inf) begin
            return {!mh[15], 8'hff, 23'd0};
        end
        // finite: value = mag * 2^(e-25), subnormal halves use e = 1
        de   = (dh[14:10] == 5'd0) ? 1 : int'(dh[14:10]);
        me   = (mh[14:10] == 5'd0) ? 1 : int'(mh[14:10]);
        amag = longint'({dh[14:10] != 5'd0, dh[9:0]}) * scq;
        bmag = longint'({mh[14:10] != 5'd0, mh[9:0]}) * mn;
        emin = (de < me) ? de : me;
        diff = (dh[15] ? -(amag <<< (de - emin)) : (amag <<< (de - emin)))
             - (mh[15] ? -(bmag <<< (me - emin)) : (bmag <<< (me - emin)));
        if (diff == 0) begin
            return {amag == 0 && bmag == 0 && dh[15] && !mh[15], 31'd0};
        end
        neg  = diff < 0;
        mag  = neg ? -diff : diff;
        lead = 0;
        for (int i = 0; i < 62; i++) begin
            if (mag[i]) lead = i;
        end
        if (lead > 23) begin
            shift   = lead - 23;
            kept    = mag >>> shift;
            rest    = mag & ((64'sd1 <<< shift) - 1);
            halfway = 64'sd1 <<< (shift - 1);
            if (rest > halfway || (rest == halfway && kept[0])) kept++;
            if (kept[24]) begin
                kept = kept >>> 1;
                lead++;
            end
        end else begin
            kept = mag <<< (23 - lead);
        end
        expo = lead + emin - 25 + 127;
        return {neg, 8'(expo), kept[22:0]};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offset <= 8'd0;
            pair_queue.delete();
            errors <= 0;
        end else begin
            if (i_push && !i_full) begin
                t_pair      p;
                logic [7:0] j;
                logic [11:0] lo_sm, hi_sm;
                offset <= (offset == LAST_OFFSET) ? 8'd0 : offset + 8'd1;
                case (offset)
                    8'd0: scale_half[7:0]  <= i_block_byte;
                    8'd1: scale_half[15:8] <= i_block_byte;
                    8'd2: min_half[7:0]    <= i_block_byte;
                    8'd3: min_half[15:8]   <= i_block_byte;
                    default: begin
                        if (offset < FIRST_QUANT) begin
                            scale_bytes[4'(offset - 8'd4)] <= i_block_byte;
                        end else begin
                            j     = offset - FIRST_QUANT;
                            lo_sm = sub_scale_min({j[6:5], 1'b0});
                            hi_sm = sub_scale_min({j[6:5], 1'b1});
                            p.low_value  = dequant_value(scale_half, min_half, lo_sm[11:6],
                                                         lo_sm[5:0], i_block_byte[3:0]);
                            p.high_value = dequant_value(scale_half, min_half, hi_sm[11:6],
                                                         hi_sm[5:0], i_block_byte[7:4]);
                            p.low_position = {j[6:5], 1'b0, j[4:0]};
                            p.block_end    = offset == LAST_OFFSET;
                            pair_queue.push_back(p);
                        end
                    end
                endcase
            end
            if (i_pop && !i_empty) begin
                t_pair want;
                t_pair got;
                got = {i_low_value, i_high_value, i_low_position, i_block_end};
                if (pair_queue.size() == 0) begin
                    if (errors < 10) $display("unexpected transfer %h", got);
                    errors <= errors + 1;
                end else begin
                    want = pair_queue.pop_front();
                    if (want != got) begin
                        if (errors < 10) begin
                            $display("mismatch lo %h/%h hi %h/%h pos %0d/%0d end %b/%b",
                                     want.low_value, got.low_value, want.high_value,
                                     got.high_value, want.low_position, got.low_position,
                                     want.block_end, got.block_end);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

[tb/tb_q4k_block_dequantizer_unit.sv]
// tb_q4k_block_dequantizer_unit: stimulus and verdict for the Q4_K dequantiser.
// Depends on q4k_block_dequantizer_unit and q4kd_result_checker.
`default_nettype none
module tb_q4k_block_dequantizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 750;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_block_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_low_value, o_high_value;
    logic [7:0]  o_low_position;
    logic        o_block_end;
    int          error_count, pending;
    int          cycles = 0;
    int          stream_offset = 0;   // offset of next byte within its block
    logic        send_burst = 1'b0;   // no idling while set
    logic        recv_burst = 1'b0;
    logic [15:0] header_half;

    always #2 i_clk = ~i_clk;

    q4k_block_dequantizer_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_block_byte(i_block_byte), .empty(empty), .pop(pop),
        .o_low_value(o_low_value), .o_high_value(o_high_value),
        .o_low_position(o_low_position), .o_block_end(o_block_end)
    );

    q4kd_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_block_byte(i_block_byte), .i_empty(empty), .i_pop(pop),
        .i_low_value(o_low_value), .i_high_value(o_high_value),
        .i_low_position(o_low_position), .i_block_end(o_block_end),
        .o_error_count(error_count), .o_pending(pending)
    );

    // Runaway guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("q4k_block_dequantizer_unit verification failed");
            $finish;
        end
    end

    // One input transfer, with a random idle gap first unless send_burst is set
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_block_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        stream_offset = (stream_offset == 143) ? 0 : stream_offset + 1;
    endtask

    // Half-float picked from the interesting classes: zeros, subnormals,
    // extremes, inf and NaN, else anything
    function automatic logic [15:0] pick_half();
        logic s;
        s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: return {s, 15'd0};
            1: return {s, 5'd0, 10'($urandom)};
            2: return {s, 5'h1f, 10'd0};
            3: return {s, 5'h1f, 10'($urandom)};
            4: return {s, 5'h1e, 10'h3ff};
            5: return {s, 5'd0, 10'd1};
            default: return 16'($urandom);
        endcase
    endfunction

    // Sender: directed start of a block, then random stream
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // largest normal scale, smallest subnormal min
        send_byte(8'hff); send_byte(8'h7b);
        send_byte(8'h01); send_byte(8'h00);
        // packed scales: all ones and all zeros so both layouts show up
        for (int k = 0; k < 12; k++) send_byte((k % 2) ? 8'h00 : 8'hff);
        send_byte(8'h00); send_byte(8'hff); send_byte(8'h0f); send_byte(8'hf0);
        send_byte(8'h5a); send_byte(8'ha5); send_byte(8'h01); send_byte(8'h80);
        // random part
        for (int n = 0; n < RANDOM_BYTES; n++) begin
            if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
            if (n == RANDOM_BYTES / 2) begin
                // hold off until the block has delivered everything
                push <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if (stream_offset == 0 || stream_offset == 2) begin
                header_half = pick_half();
                send_byte(header_half[7:0]);
            end else if (stream_offset == 1 || stream_offset == 3) begin
                send_byte(header_half[15:8]);
            end else begin
                send_byte(8'($urandom));
            end
        end
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("q4k_block_dequantizer_unit verification clean");
        end else begin
            $display("q4k_block_dequantizer_unit verification failed");
        end
        $finish;
    end

    // Receiver: one result transfer per loop, random stalls
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end
endmodule
`default_nettype wire
